// File: rtl/assert_macros.svh
// assertion macros shared by the rtl files that check themselves
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define CHC_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define CHC_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define CHC_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// File: rtl/chc_pkg.sv
// shared constants, types and the arctangent table of the compass heading unit
// no dependencies
package chc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;

    localparam int S_DATA_W  = 64;
    localparam int HEAD_W    = 16;
    localparam int M_USER_W  = 2;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int DECL_W    = 16;
    localparam int AXIS_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CALIB_DURATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECLINATION    = 2'd2;

    localparam logic [CFG_W-1:0]  CALIB_START_RST    = 32'd0;
    localparam logic [CFG_W-1:0]  CALIB_DURATION_RST = 32'd10000;
    localparam logic [DECL_W-1:0] DECLINATION_RST    = 16'd303;

    // centred sample, range, cross product
    localparam int NW = AXIS_W + 2;
    localparam int DW = AXIS_W;
    localparam int PW = NW + DW + 1;
    localparam int PRE_SHIFT = 20;
    // cordic datapath, angle, declination sum, rounded heading
    localparam int CW = PW + PRE_SHIFT + 2;
    localparam int ZW = 26;
    localparam int TW = ZW + 2;
    localparam int RND_SHIFT = 9;
    localparam int HW = TW - RND_SHIFT;

    localparam int Q_DEPTH = 4;
    localparam int QAW = $clog2(Q_DEPTH);
    localparam int QCW = $clog2(Q_DEPTH + 1);

    localparam logic signed [HW-1:0] FULL_TURN_Q7 = HW'(46080);
    localparam logic signed [ZW-1:0] ANGLE_90_Q16 = ZW'(5898240);

    // atan(2^-i) in 2^-16 degree
    localparam int ATAN_Q16 [ATAN_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic [DW-1:0]        dx;
        logic [DW-1:0]        dy;
        logic                 range_zero;
        logic                 calibrating;
    } norm_item_t;

    typedef struct packed {
        logic range_zero;
        logic calibrating;
        logic zero_angle;
    } item_tag_t;

endpackage

// File: rtl/chc_front.sv
// front end: accepts items, tests the calibration window, tracks min/max, centres axes
// depends on chc_pkg
module chc_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [chc_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [chc_pkg::CFG_W-1:0]        calib_start,
    input  logic [chc_pkg::CFG_W-1:0]        calib_duration,
    input  logic [chc_pkg::QCW-1:0]          q_level,
    output logic                             q_push,
    output chc_pkg::norm_item_t              q_push_item
);

    logic                                  a_valid_reg;
    logic signed [chc_pkg::AXIS_W-1:0]     a_x_reg, a_y_reg;
    logic                                  a_cal_reg;
    logic signed [chc_pkg::AXIS_W-1:0]     x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic signed [chc_pkg::AXIS_W-1:0]     x_lo_next, x_hi_next, y_lo_next, y_hi_next;
    logic signed [chc_pkg::AXIS_W-1:0]     in_x, in_y;
    logic [chc_pkg::CFG_W-1:0]             elapsed;
    logic                                  accept;
    logic signed [chc_pkg::NW-1:0]         rng_x, rng_y;
    logic                                  zero_x, zero_y;

    assign in_x = chc_pkg::AXIS_W'(signed'(s_tdata[chc_pkg::SAMPLE_BITS-1:0]));
    assign in_y = chc_pkg::AXIS_W'(signed'(s_tdata[chc_pkg::AXIS_W +: chc_pkg::SAMPLE_BITS]));
    assign elapsed = s_tdata[chc_pkg::S_DATA_W-1 -: chc_pkg::CFG_W] - calib_start;

    // room for this item and the one already in stage a
    assign s_tready = ({1'b0, q_level} + {{chc_pkg::QCW{1'b0}}, a_valid_reg})
                      < (chc_pkg::QCW + 1)'(chc_pkg::Q_DEPTH);
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_x_reg   <= in_x;
            a_y_reg   <= in_y;
            a_cal_reg <= (elapsed <= calib_duration);
        end
    end

    // widen the extremes while calibrating
    always_comb begin
        x_lo_next = (a_cal_reg && (a_x_reg < x_lo_reg)) ? a_x_reg : x_lo_reg;
        x_hi_next = (a_cal_reg && (a_x_reg > x_hi_reg)) ? a_x_reg : x_hi_reg;
        y_lo_next = (a_cal_reg && (a_y_reg < y_lo_reg)) ? a_y_reg : y_lo_reg;
        y_hi_next = (a_cal_reg && (a_y_reg > y_hi_reg)) ? a_y_reg : y_hi_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_lo_reg <= '0;
            x_hi_reg <= '0;
            y_lo_reg <= '0;
            y_hi_reg <= '0;
        end else if (a_valid_reg) begin
            x_lo_reg <= x_lo_next;
            x_hi_reg <= x_hi_next;
            y_lo_reg <= y_lo_next;
            y_hi_reg <= y_hi_next;
        end
    end

    assign rng_x  = chc_pkg::NW'(x_hi_next) - chc_pkg::NW'(x_lo_next);
    assign rng_y  = chc_pkg::NW'(y_hi_next) - chc_pkg::NW'(y_lo_next);
    assign zero_x = (rng_x <= chc_pkg::NW'(0));
    assign zero_y = (rng_y <= chc_pkg::NW'(0));

    assign q_push = a_valid_reg;

    always_comb begin
        q_push_item.nx = (chc_pkg::NW'(a_x_reg) <<< 1) - chc_pkg::NW'(x_lo_next)
                         - chc_pkg::NW'(x_hi_next);
        q_push_item.ny = (chc_pkg::NW'(a_y_reg) <<< 1) - chc_pkg::NW'(y_lo_next)
                         - chc_pkg::NW'(y_hi_next);
        q_push_item.dx = zero_x ? chc_pkg::DW'(1) : rng_x[chc_pkg::DW-1:0];
        q_push_item.dy = zero_y ? chc_pkg::DW'(1) : rng_y[chc_pkg::DW-1:0];
        q_push_item.range_zero  = zero_x || zero_y;
        q_push_item.calibrating = a_cal_reg;
    end

endmodule

// File: rtl/chc_queue.sv
// short fifo of centred items between the front end and the heading pipeline
// depends on chc_pkg
module chc_queue (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     wr_en,
    input  chc_pkg::norm_item_t      wr_item,
    input  logic                     rd_en,
    output chc_pkg::norm_item_t      rd_item,
    output logic [chc_pkg::QCW-1:0]  level
);

    chc_pkg::norm_item_t          mem_reg [chc_pkg::Q_DEPTH];
    logic [chc_pkg::QAW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [chc_pkg::QCW-1:0]      level_reg;

    function automatic logic [chc_pkg::QAW-1:0] ptr_inc(input logic [chc_pkg::QAW-1:0] p);
        return (p == chc_pkg::QAW'(chc_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            unique case ({wr_en, rd_en})
                2'b10:   level_reg <= level_reg + 1'b1;
                2'b01:   level_reg <= level_reg - 1'b1;
                default: level_reg <= level_reg;
            endcase
        end
    end

    assign rd_item = mem_reg[rd_ptr_reg];
    assign level   = level_reg;

endmodule

// File: rtl/chc_back.sv
// back end: cross products, pipelined cordic atan2, declination, rounding and wrap
// depends on chc_pkg
module chc_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic signed [chc_pkg::DECL_W-1:0]   declination,
    input  logic [chc_pkg::QCW-1:0]             q_level,
    input  chc_pkg::norm_item_t                 q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [chc_pkg::HEAD_W-1:0]          m_tdata,
    output logic [chc_pkg::M_USER_W-1:0]        m_tuser
);

    localparam int N = chc_pkg::CORDIC_STEPS;

    logic advance, q_valid;

    // multiply stage
    logic                           mul_valid_reg;
    logic signed [chc_pkg::PW-1:0]  mul_px_reg, mul_py_reg;
    chc_pkg::item_tag_t             mul_tag_reg;
    logic signed [chc_pkg::DW:0]    dx_s, dy_s;
    logic signed [chc_pkg::PW-1:0]  px, py;

    // cordic stages, index 0 holds the quadrant-folded vector
    logic                           cv_reg [N+1];
    logic signed [chc_pkg::CW-1:0]  cx_reg [N+1];
    logic signed [chc_pkg::CW-1:0]  cy_reg [N+1];
    logic signed [chc_pkg::ZW-1:0]  cz_reg [N+1];
    chc_pkg::item_tag_t             ctag_reg [N+1];
    logic signed [chc_pkg::CW-1:0]  cx_next [N+1];
    logic signed [chc_pkg::CW-1:0]  cy_next [N+1];
    logic signed [chc_pkg::ZW-1:0]  cz_next [N+1];
    logic signed [chc_pkg::CW-1:0]  xe, ye;

    // rounding stage
    logic                           rnd_valid_reg;
    logic signed [chc_pkg::HW-1:0]  rnd_h_reg;
    chc_pkg::item_tag_t             rnd_tag_reg;
    logic signed [chc_pkg::ZW-1:0]  ang;
    logic signed [chc_pkg::TW-1:0]  tot;

    // output register
    logic                           m_valid_reg;
    logic [chc_pkg::HEAD_W-1:0]     m_data_reg;
    logic [chc_pkg::M_USER_W-1:0]   m_user_reg;
    logic signed [chc_pkg::HW-1:0]  h_wrap;

    assign q_valid = (q_level != '0);
    assign advance = !m_valid_reg || m_tready;
    assign q_pop   = advance && q_valid;

    assign dx_s = {1'b0, q_item.dx};
    assign dy_s = {1'b0, q_item.dy};
    assign px   = q_item.nx * dy_s;
    assign py   = q_item.ny * dx_s;

    // fold the left half plane onto the right one
    assign xe = chc_pkg::CW'(mul_px_reg) <<< chc_pkg::PRE_SHIFT;
    assign ye = chc_pkg::CW'(mul_py_reg) <<< chc_pkg::PRE_SHIFT;

    always_comb begin
        if (mul_px_reg < 0 && mul_py_reg >= 0) begin
            cx_next[0] = ye;
            cy_next[0] = -xe;
            cz_next[0] = chc_pkg::ANGLE_90_Q16;
        end else if (mul_px_reg < 0) begin
            cx_next[0] = -ye;
            cy_next[0] = xe;
            cz_next[0] = -chc_pkg::ANGLE_90_Q16;
        end else begin
            cx_next[0] = xe;
            cy_next[0] = ye;
            cz_next[0] = '0;
        end
        for (int i = 0; i < N; i++) begin
            if (cy_reg[i] >= 0) begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + chc_pkg::ZW'(chc_pkg::ATAN_Q16[i]);
            end else begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - chc_pkg::ZW'(chc_pkg::ATAN_Q16[i]);
            end
        end
    end

    // declination and half-up rounding to q7
    assign ang = ctag_reg[N].zero_angle ? '0 : cz_reg[N];
    assign tot = chc_pkg::TW'(ang) + (chc_pkg::TW'(declination) <<< chc_pkg::RND_SHIFT)
                 + (chc_pkg::TW'(1) <<< (chc_pkg::RND_SHIFT - 1));

    always_comb begin
        priority if (rnd_h_reg < -chc_pkg::FULL_TURN_Q7) begin
            h_wrap = rnd_h_reg + (chc_pkg::FULL_TURN_Q7 <<< 1);
        end else if (rnd_h_reg < 0) begin
            h_wrap = rnd_h_reg + chc_pkg::FULL_TURN_Q7;
        end else if (rnd_h_reg >= (chc_pkg::FULL_TURN_Q7 <<< 1)) begin
            h_wrap = rnd_h_reg - (chc_pkg::FULL_TURN_Q7 <<< 1);
        end else if (rnd_h_reg >= chc_pkg::FULL_TURN_Q7) begin
            h_wrap = rnd_h_reg - chc_pkg::FULL_TURN_Q7;
        end else begin
            h_wrap = rnd_h_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            rnd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i <= N; i++) begin
                cv_reg[i] <= 1'b0;
            end
        end else if (advance) begin
            mul_valid_reg <= q_valid;
            cv_reg[0]     <= mul_valid_reg;
            for (int i = 0; i < N; i++) begin
                cv_reg[i+1] <= cv_reg[i];
            end
            rnd_valid_reg <= cv_reg[N];
            m_valid_reg   <= rnd_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            mul_px_reg              <= px;
            mul_py_reg              <= py;
            mul_tag_reg.range_zero  <= q_item.range_zero;
            mul_tag_reg.calibrating <= q_item.calibrating;
            mul_tag_reg.zero_angle  <= (q_item.nx == '0) && (q_item.ny == '0);
            ctag_reg[0]             <= mul_tag_reg;
            for (int i = 0; i <= N; i++) begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
            end
            for (int i = 0; i < N; i++) begin
                ctag_reg[i+1] <= ctag_reg[i];
            end
            rnd_h_reg   <= chc_pkg::HW'(tot >>> chc_pkg::RND_SHIFT);
            rnd_tag_reg <= ctag_reg[N];
            m_data_reg  <= chc_pkg::HEAD_W'(h_wrap);
            m_user_reg  <= {rnd_tag_reg.range_zero, rnd_tag_reg.calibrating};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: rtl/compass_heading_with_calibration_unit.sv
// top level of the compass heading unit with hard-iron min/max calibration
// depends on chc_pkg, chc_front, chc_queue, chc_back and assert_macros.svh
`include "assert_macros.svh"

// The unit turns magnetometer x/y samples into a heading in unsigned q7 degrees,
// 0 to under 360. While a sample's timestamp falls inside the calibration window
// (start and length set over the configuration port), the per-axis min/max are
// widened; every sample is then centred on the min/max midpoint and scaled by the
// range through cross products, fed to a cordic atan2, offset by the declination,
// rounded half up and wrapped. m_tuser flags whether the sample was calibrating
// and whether an axis had zero range. Throughput is one item per clock as long as
// results are taken: every cordic iteration is its own pipeline stage, so nothing
// iterates in place. The window test is done as the item is taken; the item then
// passes through the min/max update and centring, the queue, the multiplier, the
// quadrant fold, the cordic stages, rounding and the output register. s_tready
// drops only when the four-entry queue between front end and pipeline cannot take
// another item, which happens when m_tready is held low. Configuration should be
// written while no item is in flight.
module compass_heading_with_calibration_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input item
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [chc_pkg::S_DATA_W-1:0]       s_tdata,   // sample_x, sample_y, now_ms
    // result item
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [chc_pkg::HEAD_W-1:0]         m_tdata,   // heading_q7
    output logic [chc_pkg::M_USER_W-1:0]       m_tuser,   // calibrating, range_zero
    // configuration writes
    input  logic                               cfg_we,
    input  logic [chc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [chc_pkg::CFG_W-1:0]          cfg_wdata
);

    logic [chc_pkg::CFG_W-1:0]           calib_start_reg;
    logic [chc_pkg::CFG_W-1:0]           calib_duration_reg;
    logic signed [chc_pkg::DECL_W-1:0]   declination_reg;

    logic                                q_push, q_pop;
    chc_pkg::norm_item_t                 q_push_item, q_rd_item;
    logic [chc_pkg::QCW-1:0]             q_level;

    // config registers; an index past the list is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            calib_start_reg    <= chc_pkg::CALIB_START_RST;
            calib_duration_reg <= chc_pkg::CALIB_DURATION_RST;
            declination_reg    <= chc_pkg::DECLINATION_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                chc_pkg::CFG_CALIB_START:    calib_start_reg    <= cfg_wdata;
                chc_pkg::CFG_CALIB_DURATION: calib_duration_reg <= cfg_wdata;
                chc_pkg::CFG_DECLINATION:    declination_reg    <= cfg_wdata[chc_pkg::DECL_W-1:0];
                default: ;
            endcase
        end
    end

    // window test, min/max tracking and centring
    chc_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .calib_start    (calib_start_reg),
        .calib_duration (calib_duration_reg),
        .q_level        (q_level),
        .q_push         (q_push),
        .q_push_item    (q_push_item)
    );

    // decouples the front end from output back-pressure
    chc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (q_push),
        .wr_item (q_push_item),
        .rd_en   (q_pop),
        .rd_item (q_rd_item),
        .level   (q_level)
    );

    // products, cordic, declination, wrap, output register
    chc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .declination (declination_reg),
        .q_level     (q_level),
        .q_item      (q_rd_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // front end never overfills the queue
    `CHC_ASSERT_NEVER(a_no_overflow, aclk, aresetn, q_push && (q_level == chc_pkg::QCW'(chc_pkg::Q_DEPTH)))
    // pipeline only pops a queue that holds an item
    `CHC_ASSERT_IMPLY(a_pop_nonempty, aclk, aresetn, q_pop, q_level != '0)
    // wrapped heading always lands below a full turn
    `CHC_ASSERT_IMPLY(a_heading_range, aclk, aresetn, m_tvalid, m_tdata < chc_pkg::HEAD_W'(chc_pkg::FULL_TURN_Q7))

endmodule
